// ===== rtl/rtf_pkg.sv =====
// shared types, constants and preset table for the compressed rtf decompressor
package rtf_pkg;

  localparam int DICT_SIZE_DEF = 4096;
  localparam int PRESET_LEN    = 207;
  localparam logic [31:0] HEADER_LEN   = 32'd16;
  localparam logic [31:0] TOTAL_END    = 32'd4;
  localparam logic [31:0] RAW_END      = 32'd8;
  localparam logic [3:0]  TOKEN_START  = 4'd8;
  localparam logic [7:0]  CLOSE_BRACE  = 8'h7D;

  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_TERM = 2'd1;
  localparam logic [1:0] KIND_MARK = 2'd2;

  localparam logic [8*PRESET_LEN-1:0] PRESET_TEXT = {
    "{\\rtf1\\ansi\\mac\\deff0\\deftab720{\\fonttbl;}",
    "{\\f0\\fnil \\froman \\fswiss \\fmodern \\fscrip",
    "t \\fdecor MS Sans SerifSymbolArialTimes Ne",
    "w RomanCourier{\\colortbl\\red0\\green0\\blue0",
    "\015\012\\par \\pard\\plain\\f0\\fs20\\b\\i\\u\\tab",
    "\\tx"
  };

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [1:0]  kind;
    logic [31:0] decoded_length;
    logic        run_end;
  } rtf_result_t;

  typedef struct packed {
    logic [1:0] level;
    logic       pop;
  } rtf_q_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BYTE,
    ST_COPY,
    ST_BRACE1,
    ST_BRACE2,
    ST_TERM,
    ST_MARK
  } rtf_state_t;

  function automatic logic [7:0] preset_byte(input int unsigned idx);
    logic [7:0] b;
    b = 8'h00;
    if (idx < PRESET_LEN) begin
      b = PRESET_TEXT[8*(PRESET_LEN-1-idx) +: 8];
    end
    return b;
  endfunction

endpackage

// ===== rtl/rtf_in_if.sv =====
// compressed byte input channel
interface rtf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last_byte;

  modport source(output valid, in_byte, last_byte, input ready);
  modport sink(input valid, in_byte, last_byte, output ready);
endinterface

// ===== rtl/rtf_out_if.sv =====
// decoded result output channel
interface rtf_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic [1:0]  kind;
  logic [31:0] decoded_length;
  logic        run_end;

  modport source(output valid, out_byte, kind, decoded_length, run_end, input ready);
  modport sink(input valid, out_byte, kind, decoded_length, run_end, output ready);
endinterface

// ===== rtl/rtf_dict.sv =====
// ring dictionary memory with preset sweep and read-during-write forwarding
module rtf_dict
  import rtf_pkg::*;
#(
  parameter int DICT_SIZE = DICT_SIZE_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         clear,
  output logic                         busy,
  input  logic                         rd_en,
  input  logic [$clog2(DICT_SIZE)-1:0] rd_addr,
  output logic [7:0]                   rd_data,
  input  logic                         wr_en,
  input  logic [$clog2(DICT_SIZE)-1:0] wr_addr,
  input  logic [7:0]                   wr_data
);

  localparam int AW = $clog2(DICT_SIZE);

  logic [7:0]    mem [DICT_SIZE];
  logic [AW-1:0] sweep_addr;
  logic [7:0]    q;
  logic          fwd;
  logic [7:0]    fwd_data;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      busy       <= 1'b1;
      sweep_addr <= '0;
    end else if (busy) begin
      if (sweep_addr == AW'(DICT_SIZE - 1)) begin
        busy <= 1'b0;
      end
      sweep_addr <= sweep_addr + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[sweep_addr] <= preset_byte(int'(sweep_addr));
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      q <= mem[rd_addr];
    end
    fwd      <= rd_en && wr_en && !busy && (rd_addr == wr_addr);
    fwd_data <= wr_data;
  end

  assign rd_data = fwd ? fwd_data : q;

endmodule

// ===== rtl/rtf_outq.sv =====
// two-entry result queue in front of the output channel
module rtf_outq
  import rtf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  rtf_result_t push_data,
  output rtf_q_stat_t q_stat,
  rtf_out_if.source   egress
);

  rtf_result_t slot [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  level;
  logic        pop;

  assign pop = egress.valid && egress.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      level  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      level <= level + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
  end

  assign egress.valid          = (level != 2'd0);
  assign egress.out_byte       = slot[rd_ptr].out_byte;
  assign egress.kind           = slot[rd_ptr].kind;
  assign egress.decoded_length = slot[rd_ptr].decoded_length;
  assign egress.run_end        = slot[rd_ptr].run_end;

  assign q_stat.level = level;
  assign q_stat.pop   = pop;

endmodule

// ===== rtl/rtf_ctrl.sv =====
// header parse, token decode and copy sequencer
module rtf_ctrl
  import rtf_pkg::*;
#(
  parameter int DICT_SIZE = DICT_SIZE_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  rtf_in_if.sink                       ingress,
  input  rtf_q_stat_t                  q_stat,
  output logic                         push,
  output rtf_result_t                  push_data,
  input  logic                         dict_busy,
  output logic                         dict_clear,
  output logic                         rd_en,
  output logic [$clog2(DICT_SIZE)-1:0] rd_addr,
  input  logic [7:0]                   rd_data,
  output logic                         wr_en,
  output logic [$clog2(DICT_SIZE)-1:0] wr_addr,
  output logic [7:0]                   wr_data
);

  localparam int AW = $clog2(DICT_SIZE);

  rtf_state_t    state;
  rtf_state_t    state_next;
  logic [31:0]   byte_position;
  logic [31:0]   total_size;
  logic [31:0]   raw_size;
  logic [32:0]   emitted_count;
  logic [7:0]    flag_bits;
  logic [3:0]    token_index;
  logic          pend_valid;
  logic [7:0]    pend_byte;
  logic [AW-1:0] wpos;
  logic [7:0]    cur_byte;
  logic          cur_last;
  logic          cur_body;
  logic          cur_islast;
  logic [AW-1:0] copy_off;
  logic [4:0]    copy_len;
  logic [4:0]    issued;
  logic [4:0]    done;
  logic          rd_valid;

  logic          accept;
  logic          restart;
  logic          room;
  logic          room_after;
  logic          can_push;
  logic          cur_bit;
  logic          lit_found;
  logic [2:0]    lit_idx;
  logic          ref_start;
  logic          lit_go;
  logic          copy_final;
  logic [2:0]    count_next;
  rtf_state_t    after_st;

  assign accept  = ingress.valid && ingress.ready;
  assign restart = rst || ((state == ST_MARK) && can_push);

  always_comb begin
    room       = emitted_count < ({1'b0, raw_size} + 33'd3);
    room_after = (emitted_count + 33'd1) < ({1'b0, raw_size} + 33'd3);
    can_push   = (q_stat.level != 2'd2) || q_stat.pop;
    cur_bit    = flag_bits[token_index[2:0]];
    lit_found  = 1'b0;
    lit_idx    = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if ((i >= int'(token_index)) && !flag_bits[i]) begin
        lit_found = 1'b1;
        lit_idx   = 3'(i);
      end
    end
    ref_start  = cur_bit && !cur_islast;
    lit_go     = cur_body && !token_index[3] && !pend_valid && !ref_start && lit_found &&
                 (!room || can_push);
    copy_final = (done == copy_len - 5'd1);
    after_st   = cur_last ? ST_BRACE1 : ST_IDLE;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_BYTE;
        end
      end
      ST_BYTE: begin
        if (!cur_body || token_index[3]) begin
          state_next = after_st;
        end else if (pend_valid) begin
          state_next = ST_COPY;
        end else if (ref_start || !lit_found || lit_go) begin
          state_next = after_st;
        end
      end
      ST_COPY: begin
        if (rd_valid && copy_final) begin
          state_next = after_st;
        end
      end
      ST_BRACE1: begin
        if (!room || can_push) begin
          state_next = ST_BRACE2;
        end
      end
      ST_BRACE2: begin
        if (!room || can_push) begin
          state_next = ST_TERM;
        end
      end
      ST_TERM: begin
        if (!room || can_push) begin
          state_next = ST_MARK;
        end
      end
      ST_MARK: begin
        if (can_push) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ingress.ready = (state == ST_IDLE) && !dict_busy;
    push          = 1'b0;
    push_data     = '0;
    rd_en         = 1'b0;
    rd_addr       = copy_off + AW'(issued);
    wr_en         = 1'b0;
    wr_addr       = wpos;
    wr_data       = cur_byte;
    dict_clear    = 1'b0;
    count_next    = 3'd0;
    case (state)
      ST_BYTE: begin
        if (lit_go) begin
          wr_en              = 1'b1;
          push               = room;
          push_data.out_byte = cur_byte;
          push_data.run_end  = !cur_last;
        end
      end
      ST_COPY: begin
        if (rd_valid) begin
          wr_en              = 1'b1;
          wr_data            = rd_data;
          push               = room;
          push_data.out_byte = rd_data;
          push_data.run_end  = !cur_last && (copy_final || !room_after);
        end
        count_next = {1'b0, q_stat.level} + 3'(push) - 3'(q_stat.pop);
        rd_en      = (issued != copy_len) && (count_next <= 3'd1);
      end
      ST_BRACE1, ST_BRACE2: begin
        push               = room && can_push;
        push_data.out_byte = CLOSE_BRACE;
      end
      ST_TERM: begin
        push           = room && can_push;
        push_data.kind = KIND_TERM;
      end
      ST_MARK: begin
        push                     = can_push;
        push_data.kind           = KIND_MARK;
        push_data.decoded_length = emitted_count[32] ? 32'hFFFF_FFFF : emitted_count[31:0];
        push_data.run_end        = 1'b1;
        dict_clear               = can_push;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (restart) begin
      byte_position <= '0;
      total_size    <= '0;
      raw_size      <= '0;
      emitted_count <= '0;
      flag_bits     <= '0;
      token_index   <= TOKEN_START;
      pend_valid    <= 1'b0;
      pend_byte     <= '0;
      wpos          <= AW'(PRESET_LEN);
      rd_valid      <= 1'b0;
    end else begin
      rd_valid <= rd_en;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            cur_byte   <= ingress.in_byte;
            cur_last   <= ingress.last_byte;
            cur_body   <= (byte_position >= HEADER_LEN) && (byte_position < total_size);
            cur_islast <= ingress.last_byte ||
                          (({1'b0, byte_position} + 33'd1) == {1'b0, total_size});
            if (byte_position != 32'hFFFF_FFFF) begin
              byte_position <= byte_position + 32'd1;
            end
            if (byte_position < TOTAL_END) begin
              total_size[8*byte_position[1:0] +: 8] <=
                total_size[8*byte_position[1:0] +: 8] | ingress.in_byte;
            end else if (byte_position < RAW_END) begin
              raw_size[8*byte_position[1:0] +: 8] <=
                raw_size[8*byte_position[1:0] +: 8] | ingress.in_byte;
            end
          end
        end
        ST_BYTE: begin
          if (cur_body) begin
            if (token_index[3]) begin
              flag_bits   <= cur_byte;
              token_index <= 4'd0;
            end else if (pend_valid) begin
              copy_off    <= AW'({pend_byte, cur_byte[7:4]});
              copy_len    <= {1'b0, cur_byte[3:0]} + 5'd2;
              issued      <= 5'd0;
              done        <= 5'd0;
              pend_valid  <= 1'b0;
              token_index <= token_index + 4'd1;
            end else if (ref_start) begin
              pend_valid <= 1'b1;
              pend_byte  <= cur_byte;
            end else if (lit_found) begin
              if (lit_go) begin
                wpos        <= wpos + AW'(1);
                token_index <= {1'b0, lit_idx} + 4'd1;
                if (room) begin
                  emitted_count <= emitted_count + 33'd1;
                end
              end
            end else begin
              flag_bits   <= cur_byte;
              token_index <= 4'd0;
            end
          end
        end
        ST_COPY: begin
          if (rd_en) begin
            issued <= issued + 5'd1;
          end
          if (rd_valid) begin
            done <= done + 5'd1;
            wpos <= wpos + AW'(1);
            if (room) begin
              emitted_count <= emitted_count + 33'd1;
            end
          end
        end
        ST_BRACE1, ST_BRACE2: begin
          if (room && can_push) begin
            emitted_count <= emitted_count + 33'd1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/compressed_rtf_decompressor.sv =====
// top level of the compressed rtf stream decompressor
// Takes the compressed buffer one byte per transaction, header first, and
// returns decoded bytes, two closing braces, a null terminator and an end
// marker with the decoded length; run_end flags the last result of each input
// byte. Each input byte is taken in ST_IDLE and decoded in ST_BYTE; the
// second byte of a reference goes on to ST_COPY, which copies length bytes,
// with length from 2 to 17, one byte per cycle while the result queue has
// room, through the single read port of the dictionary memory. The closing
// steps through ST_BRACE1, ST_BRACE2, ST_TERM and ST_MARK. After reset and
// after every end marker the dictionary is reloaded with the preset text in
// a sweep of all DICT_SIZE entries (4096 by default), taking no input byte.
module compressed_rtf_decompressor
  import rtf_pkg::*;
#(
  parameter int DICT_SIZE = DICT_SIZE_DEF
) (
  input  logic      clk,
  input  logic      rst,
  rtf_in_if.sink    ingress,
  rtf_out_if.source egress
);

  localparam int AW = $clog2(DICT_SIZE);

  rtf_q_stat_t   q_stat;
  logic          push;
  rtf_result_t   push_data;
  logic          dict_busy;
  logic          dict_clear;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;

  rtf_ctrl #(
    .DICT_SIZE(DICT_SIZE)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .ingress   (ingress),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data),
    .dict_busy (dict_busy),
    .dict_clear(dict_clear),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  rtf_dict #(
    .DICT_SIZE(DICT_SIZE)
  ) u_dict (
    .clk    (clk),
    .rst    (rst),
    .clear  (dict_clear),
    .busy   (dict_busy),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data)
  );

  rtf_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_data),
    .q_stat   (q_stat),
    .egress   (egress)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> ((q_stat.level != 2'd2) || q_stat.pop))
    else $error("result queue overflow");

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    q_stat.level != 2'd3)
    else $error("result queue level out of range");

  a_idle_while_sweep: assert property (@(posedge clk) disable iff (rst)
    dict_busy |-> (!rd_en && !wr_en))
    else $error("dictionary accessed during preset sweep");

  a_sweep_after_mark: assert property (@(posedge clk) disable iff (rst)
    (push && (push_data.kind == KIND_MARK)) |=> dict_busy)
    else $error("no preset sweep after end marker");

endmodule
